FILE: design/kps_pkg.sv
// Shared types, constants and key code table for the keypad scanner.
`default_nettype none
package kps_pkg;
	localparam int COUNT_WIDTH = 16;
	localparam int REG_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [REG_WIDTH-1:0] reg_t;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam cfg_index_t REG_SETTLE = 2'd0;
	localparam cfg_index_t REG_DEBOUNCE = 2'd1;

	localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam reg_t SETTLE_RESET = 16'd2;
	localparam reg_t DEBOUNCE_RESET = 16'd25;

	typedef struct packed {
		logic [3:0] col_drive;
		logic       key_valid;
		logic [3:0] key_code;
	} kps_result_t;

	function automatic count_t clip_limit(input reg_t v);
		logic [32:0] ext;
		ext = 33'(v);
		if (ext > 33'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return count_t'(ext);
	endfunction

	function automatic logic [3:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
		logic [3:0] code;
		code = 4'd0;
		unique case ({col, row})
			4'h0: code = 4'd1;
			4'h1: code = 4'd4;
			4'h2: code = 4'd7;
			4'h3: code = 4'd14;
			4'h4: code = 4'd2;
			4'h5: code = 4'd5;
			4'h6: code = 4'd8;
			4'h7: code = 4'd0;
			4'h8: code = 4'd3;
			4'h9: code = 4'd6;
			4'hA: code = 4'd9;
			4'hB: code = 4'd15;
			4'hC: code = 4'd10;
			4'hD: code = 4'd11;
			4'hE: code = 4'd12;
			4'hF: code = 4'd13;
			default: code = 4'd0;
		endcase
		return code;
	endfunction
endpackage
`default_nettype wire

FILE: design/kps_fsm.sv
// Scan state machine with wait counter and configuration registers.
`default_nettype none
module kps_fsm (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [3:0]          rows,
	input  wire logic                cfg_we,
	input  wire kps_pkg::cfg_index_t cfg_index,
	input  wire kps_pkg::reg_t       cfg_data,
	output kps_pkg::kps_result_t     result
);
	import kps_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_PDEB    = 3'd1;
	localparam logic [2:0] PH_SCAN    = 3'd2;
	localparam logic [2:0] PH_RELEASE = 3'd3;
	localparam logic [2:0] PH_RDEB    = 3'd4;

	reg_t       settle_q;
	reg_t       debounce_q;
	logic [2:0] phase_q;
	logic [1:0] col_q;
	count_t     count_q;
	logic [3:0] held_q;

	logic [2:0] phase_d;
	logic [1:0] col_d;
	count_t     count_d;
	logic [3:0] held_d;
	count_t     deb;
	count_t     settle_lim;
	count_t     bumped;
	logic [1:0] first_row;
	logic       any_row;

	assign deb = clip_limit(debounce_q);
	assign settle_lim = clip_limit((settle_q == '0) ? reg_t'(1) : settle_q);
	assign bumped = (count_q == COUNT_MAX) ? count_q : count_q + count_t'(1);
	assign any_row = (rows != 4'd0);

	always_comb begin
		if (rows[0]) begin
			first_row = 2'd0;
		end else if (rows[1]) begin
			first_row = 2'd1;
		end else if (rows[2]) begin
			first_row = 2'd2;
		end else begin
			first_row = 2'd3;
		end
	end

	always_comb begin
		phase_d = phase_q;
		col_d = col_q;
		count_d = count_q;
		held_d = held_q;
		result.col_drive = 4'hF;
		result.key_valid = 1'b0;
		result.key_code = 4'd0;
		unique case (phase_q)
			PH_PDEB: begin
				count_d = bumped;
				if (bumped >= deb) begin
					phase_d = PH_SCAN;
					col_d = 2'd0;
					count_d = '0;
				end
			end
			PH_SCAN: begin
				result.col_drive = 4'b0001 << col_q;
				count_d = bumped;
				if (bumped >= settle_lim) begin
					count_d = '0;
					if (any_row) begin
						held_d = key_lookup(col_q, first_row);
						phase_d = PH_RELEASE;
					end else begin
						col_d = col_q + 2'd1;
					end
				end
			end
			PH_RELEASE: begin
				count_d = bumped;
				if (bumped >= settle_lim && !any_row) begin
					count_d = '0;
					if (deb == '0) begin
						result.key_valid = 1'b1;
						result.key_code = held_q;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_RDEB;
					end
				end
			end
			PH_RDEB: begin
				count_d = bumped;
				if (bumped >= deb) begin
					result.key_valid = 1'b1;
					result.key_code = held_q;
					phase_d = PH_IDLE;
					count_d = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (any_row) begin
					count_d = '0;
					if (deb == '0) begin
						phase_d = PH_SCAN;
						col_d = 2'd0;
					end else begin
						phase_d = PH_PDEB;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE:   settle_q <= cfg_data;
				REG_DEBOUNCE: debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			col_q <= 2'd0;
			count_q <= '0;
			held_q <= 4'd0;
		end else if (step) begin
			phase_q <= phase_d;
			col_q <= col_d;
			count_q <= count_d;
			held_q <= held_d;
		end
	end

`ifndef SYNTHESIS
	a_scan_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_SCAN |-> $onehot(result.col_drive))
		else $error("column drive not one-hot during scan");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.key_valid |=> phase_q == PH_IDLE)
		else $error("phase not idle after key emit");

	a_code_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!result.key_valid |-> result.key_code == 4'd0)
		else $error("key code nonzero without key valid");

	a_hold_on_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(count_q) && $stable(col_q))
		else $error("scan state moved without a step");
`endif
endmodule
`default_nettype wire

FILE: design/matrix_keypad_scanner_unit.sv
// Top level of the 4x4 keypad scanner: input register, scan logic, result register.
`default_nettype none
// One row sample item in gives one result item out. Items flow at one per cycle:
// the scan state (phase, column, wait counter, held code) is updated in the
// cycle an item moves from the input register into the result register, so a new
// item is taken every cycle while the result side keeps up. An item goes through
// both registers before it is offered. Configuration writes take effect at
// once and are meant to be issued while no item is in flight.
module matrix_keypad_scanner_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [3:0]          row_levels,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [3:0]               col_drive,
	output logic                     key_valid,
	output logic [3:0]               key_code,
	input  wire logic                cfg_we,
	input  wire kps_pkg::cfg_index_t cfg_index,
	input  wire kps_pkg::reg_t       cfg_data
);
	import kps_pkg::*;

	logic        v_s1;
	logic [3:0]  rows_s1;
	logic        v_s2;
	kps_result_t res_s2;
	kps_result_t res;
	logic        advance;
	logic        step;

	assign advance = !v_s2 || out_ready;
	assign step = v_s1 && advance;
	assign in_ready = !v_s1 || advance;

	kps_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rows      (rows_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rows_s1 <= row_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid = v_s2;
	assign col_drive = res_s2.col_drive;
	assign key_valid = res_s2.key_valid;
	assign key_code = res_s2.key_code;
endmodule
`default_nettype wire
